// File: hw/rtl/fcp_pkg.sv
package fcp_pkg;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_NAV       = 4'd1;
  localparam logic [3:0] EV_FLOOR_A   = 4'd2;
  localparam logic [3:0] EV_CEIL_A    = 4'd3;
  localparam logic [3:0] EV_FLOOR_B   = 4'd4;
  localparam logic [3:0] EV_CEIL_B    = 4'd5;
  localparam logic [3:0] EV_TIME      = 4'd6;
  localparam logic [3:0] EV_DATE      = 4'd7;
  localparam logic [3:0] EV_CFG_OTHER = 4'd8;
  localparam logic [3:0] EV_INFO      = 4'd9;
  localparam logic [3:0] EV_RESET     = 4'd10;
  localparam logic [3:0] EV_UNKNOWN   = 4'd11;

  typedef logic [7:0] char_t;

  localparam char_t CH_OPEN  = 8'h40;  // '@'
  localparam char_t CH_CLOSE = 8'h23;  // '#'
  localparam char_t CH_ZERO  = 8'h30;  // '0'
  localparam char_t CH_NINE  = 8'h39;  // '9'
  localparam char_t CH_LC_A  = 8'h61;  // 'a'
  localparam char_t CH_LC_Z  = 8'h7A;  // 'z'
  localparam char_t CH_A     = 8'h41;
  localparam char_t CH_B     = 8'h42;
  localparam char_t CH_C     = 8'h43;
  localparam char_t CH_D     = 8'h44;
  localparam char_t CH_H     = 8'h48;
  localparam char_t CH_I     = 8'h49;
  localparam char_t CH_N     = 8'h4E;
  localparam char_t CH_P     = 8'h50;
  localparam char_t CH_R     = 8'h52;
  localparam char_t CH_S     = 8'h53;
  localparam char_t CH_T     = 8'h54;
  localparam char_t CH_W     = 8'h57;
  localparam char_t CH_Y     = 8'h59;

  function automatic char_t up_case(input char_t c);
    if (c >= CH_LC_A && c <= CH_LC_Z) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [5:0] nav_of(input char_t c);
    logic [5:0] code;
    unique case (up_case(c))
      CH_W:    code = 6'd1;
      CH_S:    code = 6'd2;
      CH_A:    code = 6'd4;
      CH_D:    code = 6'd8;
      CH_Y:    code = 6'd16;
      CH_N:    code = 6'd32;
      default: code = 6'd0;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] cfg_kind(input char_t target, input char_t sub);
    logic [3:0] kind;
    char_t t;
    char_t s;
    t = up_case(target);
    s = up_case(sub);
    kind = EV_CFG_OTHER;
    if (t == CH_A) begin
      if (s == CH_P) kind = EV_FLOOR_A;
      else if (s == CH_T) kind = EV_CEIL_A;
    end else if (t == CH_B) begin
      if (s == CH_P) kind = EV_FLOOR_B;
      else if (s == CH_T) kind = EV_CEIL_B;
    end else if (t == CH_H) begin
      kind = EV_TIME;
    end else if (t == CH_D) begin
      kind = EV_DATE;
    end
    return kind;
  endfunction

endpackage

// File: hw/rtl/fcp_ram.sv
module fcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/fcp_mac.sv
// Shared decimal step: acc * 10 + (digit character - '0'), kept to 16 bits.
module fcp_mac (
  input  logic [15:0]          acc,
  input  fcp_pkg::char_t       ch,
  output logic [15:0]          sum
);
  import fcp_pkg::*;

  logic [15:0] times_ten;

  assign times_ten = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
  assign sum = times_ten + {8'd0, ch} - {8'd0, CH_ZERO};

endmodule

// File: hw/rtl/framed_command_parser.sv
// Serial command front end. Each received word on the rx channel (rx_valid,
// rx_stall, rx_byte) produces exactly one result word on the ev channel
// (ev_valid, ev_stall and the result fields), which echoes the byte and
// reports a navigation code, nothing (inside a frame) or a decoded command.
// Bytes are kept in a BUFFER_DEPTH-entry ring; '@' opens a frame, '#' closes it.
// An ordinary byte is decoded at acceptance and its result is shown in the
// next cycle. A closing '#' starts a sequencer that reads the ring one entry
// per cycle through a single registered read port and feeds each character
// to one shared multiply-by-ten-and-add unit: states S_CMD, S_TGT, S_SUB and
// S_DEC fetch the command, target and sub letters, S_DIG walks each entry
// from index 2 up to the close when the close sits past index 3, S_PAIR
// walks the three time/date digit pairs, and S_DONE posts the result.
// One byte is in flight at a time, so ordinary bytes go through at one per
// cycle while ev_stall is low; rx_stall is high while the sequencer runs
// or while a result waits in the output register under ev_stall. The result
// register holds its word steadily until the receiver takes it.
// Reset clears the ring write position, the frame flag, the per-entry valid
// bits (an unwritten entry reads as zero) and the output valid flag at once.
module framed_command_parser #(
  parameter int BUFFER_DEPTH = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  fcp_pkg::char_t       rx_byte,
  output logic                 ev_valid,
  input  logic                 ev_stall,
  output fcp_pkg::char_t       echo_byte,
  output logic [3:0]           event_kind,
  output logic [5:0]           nav_code,
  output logic [15:0]          number,
  output logic [7:0]           field_first,
  output logic [7:0]           field_second,
  output logic [7:0]           field_third
);
  import fcp_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_TGT  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;
  localparam logic [2:0] S_PAIR = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [AW-1:0] IDX_CMD   = AW'(1);
  localparam logic [AW-1:0] IDX_TGT   = AW'(2);
  localparam logic [AW-1:0] IDX_SUB   = AW'(3);
  localparam logic [AW-1:0] IDX_LAST  = AW'(8);
  localparam logic [AW-1:0] IDX_FIRST = AW'(4);
  localparam logic [AW-1:0] IDX_SEC   = AW'(6);
  localparam logic [AW-1:0] IDX_TOP   = AW'(BUFFER_DEPTH - 1);

  logic [2:0]              state;
  logic [AW-1:0]           wpos;
  logic                    in_frame;
  logic [BUFFER_DEPTH-1:0] valid;
  logic                    valid_q;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           close_pos;
  char_t                   cmd;
  char_t                   target;
  logic [3:0]              kind;
  logic [15:0]             acc_num;
  logic [7:0]              pair;
  logic [7:0]              fld1;
  logic [7:0]              fld2;
  logic [7:0]              fld3;

  logic                    accept;
  logic                    closing;
  logic                    ev_valid_next;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           rd_addr;
  char_t                   rd_data;
  char_t                   ch;
  logic [15:0]             mac_acc;
  logic [15:0]             mac_sum;
  logic                    more_digits;
  logic                    long_frame;
  logic                    time_date;
  logic [3:0]              dec_kind;

  assign accept   = rx_valid && !rx_stall;
  assign rx_stall = (state != S_IDLE) || (ev_valid && ev_stall);
  assign closing  = (rx_byte == CH_CLOSE) && in_frame;
  assign waddr    = (rx_byte == CH_OPEN) ? '0 : wpos;

  // A word is posted for every accepted ordinary byte and at the end of a
  // frame decode; otherwise the register holds until the receiver takes it.
  assign ev_valid_next = (accept && !closing) || (state == S_DONE) ||
                         (ev_valid && ev_stall);

  // Entries never written since the last clear read as zero.
  assign ch = valid_q ? rd_data : '0;

  assign long_frame  = close_pos > IDX_SUB;
  assign more_digits = ({1'b0, idx} + 1'b1) < {1'b0, close_pos};
  assign time_date   = (kind == EV_TIME) || (kind == EV_DATE);
  assign dec_kind    = cfg_kind(target, ch);

  always_comb begin
    unique case (state)
      S_CMD:   rd_addr = IDX_CMD;
      S_TGT:   rd_addr = IDX_TGT;
      S_SUB:   rd_addr = IDX_SUB;
      S_DEC:   rd_addr = long_frame ? IDX_TGT : IDX_SUB;
      S_DIG:   rd_addr = more_digits ? idx + 1'b1 : IDX_SUB;
      S_PAIR:  rd_addr = (idx == IDX_LAST) ? '0 : idx + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  // The shared unit accumulates the frame number while walking digits and
  // one two-digit field at a time while walking the time/date pairs.
  always_comb begin
    if (state == S_PAIR) begin
      mac_acc = idx[0] ? 16'd0 : {8'd0, pair};
    end else begin
      mac_acc = acc_num;
    end
  end

  fcp_mac u_mac (
    .acc (mac_acc),
    .ch  (ch),
    .sum (mac_sum)
  );

  fcp_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (rx_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wpos     <= '0;
      in_frame <= 1'b0;
      valid    <= '0;
      valid_q  <= 1'b0;
      ev_valid <= 1'b0;
    end else begin
      valid_q  <= valid[rd_addr];
      idx      <= rd_addr;
      ev_valid <= ev_valid_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            valid[waddr] <= 1'b1;
            wpos         <= (waddr == IDX_TOP) ? '0 : waddr + 1'b1;
            echo_byte    <= rx_byte;
            acc_num      <= '0;
            fld1         <= '0;
            fld2         <= '0;
            fld3         <= '0;
            close_pos    <= waddr;
            if (closing) begin
              in_frame <= 1'b0;
              state    <= S_CMD;
            end else begin
              number       <= '0;
              field_first  <= '0;
              field_second <= '0;
              field_third  <= '0;
              if (rx_byte == CH_OPEN || in_frame) begin
                in_frame   <= 1'b1;
                event_kind <= EV_NONE;
                nav_code   <= '0;
              end else begin
                event_kind <= EV_NAV;
                nav_code   <= nav_of(rx_byte);
              end
            end
          end
        end
        S_CMD: begin
          state <= S_TGT;
        end
        S_TGT: begin
          cmd   <= up_case(ch);
          state <= S_SUB;
        end
        S_SUB: begin
          target <= ch;
          state  <= S_DEC;
        end
        S_DEC: begin
          priority if (cmd == CH_C) begin
            kind <= dec_kind;
            if (long_frame) begin
              state <= S_DIG;
            end else if (dec_kind == EV_TIME || dec_kind == EV_DATE) begin
              state <= S_PAIR;
            end else begin
              state <= S_DONE;
            end
          end else if (cmd == CH_I) begin
            kind  <= EV_INFO;
            state <= S_DONE;
          end else if (cmd == CH_R) begin
            kind  <= EV_RESET;
            state <= S_DONE;
          end else begin
            kind  <= EV_UNKNOWN;
            state <= S_DONE;
          end
        end
        S_DIG: begin
          if (is_digit(ch)) begin
            acc_num <= mac_sum;
          end
          if (!more_digits) begin
            state <= time_date ? S_PAIR : S_DONE;
          end
        end
        S_PAIR: begin
          if (idx[0]) begin
            pair <= mac_sum[7:0];
          end else if (idx == IDX_FIRST) begin
            fld1 <= mac_sum[7:0];
          end else if (idx == IDX_SEC) begin
            fld2 <= mac_sum[7:0];
          end else begin
            fld3 <= mac_sum[7:0];
          end
          if (idx == IDX_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Post the frame result and empty the ring in one step.
          event_kind   <= kind;
          nav_code     <= '0;
          number       <= acc_num;
          field_first  <= fld1;
          field_second <= fld2;
          field_third  <= fld3;
          valid        <= '0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A byte is only taken while the sequencer is at rest.
  assert property (@(posedge clk) disable iff (rst) accept |-> state == S_IDLE)
    else $error("byte accepted while a frame is being decoded");

  // The output register is free when a frame result is posted.
  assert property (@(posedge clk) disable iff (rst) state == S_DONE |-> !ev_valid)
    else $error("frame result would overwrite a pending word");

  // The ring is empty right after a frame.
  assert property (@(posedge clk) disable iff (rst) state == S_DONE |=> valid == '0)
    else $error("ring not cleared after frame");

  // A navigation code only travels with a navigation event.
  assert property (@(posedge clk) disable iff (rst)
    ev_valid && nav_code != '0 |-> event_kind == EV_NAV)
    else $error("navigation code on a non-navigation event");

endmodule
